FILE: src/ray_plate_nearest_hit_assert.svh
// assertion macros for the nearest plate ray caster
// expects clk and rst to be visible where a macro is used
`ifndef RAY_PLATE_NEAREST_HIT_ASSERT_SVH
`define RAY_PLATE_NEAREST_HIT_ASSERT_SVH

// same-cycle implication
`define RPNH_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RPNH_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/rpnh_pkg.sv
// shared types, constants and the angle threshold table for the ray caster
// no dependencies
`default_nettype none

package rpnh_pkg;

  localparam int MAX_PLATES = 128;
  localparam int PLATE_AW   = (MAX_PLATES > 1) ? $clog2(MAX_PLATES) : 1;
  localparam int CNT_W      = $clog2(MAX_PLATES + 1);
  localparam int DEPTH_END  = 720;
  localparam int ANGLE_MAX  = 90;
  localparam int DIV_CELLS  = 12;
  localparam int CFG_IDX_W  = 2;

  localparam logic [7:0] COUNT_RESET  = 8'd10;
  localparam logic [7:0] LENGTH_RESET = 8'd60;

  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_RAY   = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNT  = 2'd0,
    REG_LENGTH = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic signed [9:0] left;
    logic [9:0]        depth;
  } plate_t;

  // word handed from one divide cell to the next
  typedef struct packed {
    logic              valid;
    logic              neg;
    logic signed [9:0] left;
    logic [9:0]        depth;
    logic [9:0]        rem;
    logic [11:0]       dq;    // dividend bits still to go, quotient bits shifted in
  } div_t;

  // floor(720*cot(k deg)), 4095 below k=20; angle >= k exactly when |end x| <= this
  function automatic logic [11:0] cot_limit(input logic [6:0] k);
    logic [11:0] lim;
    case (k) inside
      [7'd1:7'd19]: lim = 12'd4095;
      7'd20: lim = 12'd1978;  7'd21: lim = 12'd1875;  7'd22: lim = 12'd1782;
      7'd23: lim = 12'd1696;  7'd24: lim = 12'd1617;  7'd25: lim = 12'd1544;
      7'd26: lim = 12'd1476;  7'd27: lim = 12'd1413;  7'd28: lim = 12'd1354;
      7'd29: lim = 12'd1298;  7'd30: lim = 12'd1247;  7'd31: lim = 12'd1198;
      7'd32: lim = 12'd1152;  7'd33: lim = 12'd1108;  7'd34: lim = 12'd1067;
      7'd35: lim = 12'd1028;  7'd36: lim = 12'd990;   7'd37: lim = 12'd955;
      7'd38: lim = 12'd921;   7'd39: lim = 12'd889;   7'd40: lim = 12'd858;
      7'd41: lim = 12'd828;   7'd42: lim = 12'd799;   7'd43: lim = 12'd772;
      7'd44: lim = 12'd745;   7'd45: lim = 12'd720;   7'd46: lim = 12'd695;
      7'd47: lim = 12'd671;   7'd48: lim = 12'd648;   7'd49: lim = 12'd625;
      7'd50: lim = 12'd604;   7'd51: lim = 12'd583;   7'd52: lim = 12'd562;
      7'd53: lim = 12'd542;   7'd54: lim = 12'd523;   7'd55: lim = 12'd504;
      7'd56: lim = 12'd485;   7'd57: lim = 12'd467;   7'd58: lim = 12'd449;
      7'd59: lim = 12'd432;   7'd60: lim = 12'd415;   7'd61: lim = 12'd399;
      7'd62: lim = 12'd382;   7'd63: lim = 12'd366;   7'd64: lim = 12'd351;
      7'd65: lim = 12'd335;   7'd66: lim = 12'd320;   7'd67: lim = 12'd305;
      7'd68: lim = 12'd290;   7'd69: lim = 12'd276;   7'd70: lim = 12'd262;
      7'd71: lim = 12'd247;   7'd72: lim = 12'd233;   7'd73: lim = 12'd220;
      7'd74: lim = 12'd206;   7'd75: lim = 12'd192;   7'd76: lim = 12'd179;
      7'd77: lim = 12'd166;   7'd78: lim = 12'd153;   7'd79: lim = 12'd139;
      7'd80: lim = 12'd126;   7'd81: lim = 12'd114;   7'd82: lim = 12'd101;
      7'd83: lim = 12'd88;    7'd84: lim = 12'd75;    7'd85: lim = 12'd62;
      7'd86: lim = 12'd50;    7'd87: lim = 12'd37;    7'd88: lim = 12'd25;
      7'd89: lim = 12'd12;    7'd90: lim = 12'd0;
      default: lim = 12'd0;
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

FILE: src/rpnh_ifs.sv
// valid/ready channels of the ray caster: command, result and register write
// depends on rpnh_pkg
`default_nettype none

interface rpnh_cmd_if;
  logic              valid;
  logic              ready;
  logic              command;
  logic [6:0]        slot;
  logic signed [9:0] plate_x;
  logic [9:0]        plate_y;
  logic signed [11:0] ray_end_x;
  modport source (output valid, command, slot, plate_x, plate_y, ray_end_x, input ready);
  modport sink (input valid, command, slot, plate_x, plate_y, ray_end_x, output ready);
endinterface

interface rpnh_res_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [11:0] end_x;
  logic [9:0]         end_y;
  logic [6:0]         angle_deg;
  modport source (output valid, hit, end_x, end_y, angle_deg, input ready);
  modport sink (input valid, hit, end_x, end_y, angle_deg, output ready);
endinterface

interface rpnh_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rpnh_pkg::CFG_IDX_W-1:0] index;
  logic [7:0]                     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/rpnh_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module rpnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/rpnh_div_cell.sv
// one cell of the divide-by-720 chain: shifts in one dividend bit per cell
// depends on rpnh_pkg
`default_nettype none

module rpnh_div_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire rpnh_pkg::div_t d_in,
  output rpnh_pkg::div_t      d_out
);

  logic [10:0] trial;
  logic        ge;
  logic [9:0]  rem_next;

  always_comb begin
    trial    = {d_in.rem, d_in.dq[11]};
    ge       = trial >= 11'(rpnh_pkg::DEPTH_END);
    rem_next = ge ? 10'(trial - 11'(rpnh_pkg::DEPTH_END)) : trial[9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else begin
      d_out.valid <= d_in.valid;
    end
    d_out.neg   <= d_in.neg;
    d_out.left  <= d_in.left;
    d_out.depth <= d_in.depth;
    d_out.rem   <= rem_next;
    d_out.dq    <= {d_in.dq[10:0], ge};
  end

endmodule

`default_nettype wire

FILE: src/rpnh_angle.sv
// ray angle in whole degrees, binary search over the cotangent threshold table
// depends on rpnh_pkg
`default_nettype none

module rpnh_angle (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [11:0] mag,
  output logic             busy,
  output logic [6:0]       angle
);

  logic [11:0] mag_q;
  logic [2:0]  bitpos;
  logic [6:0]  trial;
  logic        take;

  always_comb begin
    trial = angle | (7'd1 << bitpos);
    take  = (trial <= 7'(rpnh_pkg::ANGLE_MAX)) && (mag_q <= rpnh_pkg::cot_limit(trial));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy   <= 1'b1;
      mag_q  <= mag;
      angle  <= 7'd0;
      bitpos <= 3'd6;
    end else if (busy) begin
      if (take) begin
        angle <= trial;
      end
      if (bitpos == 3'd0) begin
        busy <= 1'b0;
      end else begin
        bitpos <= bitpos - 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/ray_plate_nearest_hit.sv
// Nearest plate ray caster. A store word writes one plate (left x, depth) into a
// 128-entry RAM. A ray word walks slots 0 .. min(plate_count,128)-1, one RAM
// read per cycle, multiplies depth by |end x| and passes each product down a
// chain of 12 divide cells (one quotient bit per cell) before the hit test and
// nearest-depth update. The time from accept to result is governed by the
// single RAM read port, the depth of the divide chain and the 7-step angle
// search. One ray is in work at a time; a new word is taken while the previous
// result still waits in the output register. Register writes are taken every
// cycle; the plate RAM has no reset.
`default_nettype none

module ray_plate_nearest_hit (
  input wire logic  clk,
  input wire logic  rst,
  rpnh_cmd_if.sink  cmd,
  rpnh_res_if.source res,
  rpnh_cfg_if.sink  cfg
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                          state;
  logic [rpnh_pkg::CNT_W-1:0]      idx;
  logic [rpnh_pkg::CNT_W-1:0]      n_lim;
  logic                            issue;
  logic                            cmd_accept;
  logic                            ray_accept;
  logic                            store_we;
  logic [7:0]                      plate_count;
  logic [7:0]                      plate_length;
  logic                            ex_neg;
  logic [11:0]                     ex_mag;
  logic [11:0]                     ray_mag;
  logic                            rd_valid;
  rpnh_pkg::plate_t                plate_rd;
  logic [21:0]                     prod;
  rpnh_pkg::div_t                  m_stage;
  rpnh_pkg::div_t                  chain [rpnh_pkg::DIV_CELLS+1];
  rpnh_pkg::div_t                  fin;
  logic                            pipe_any;
  logic signed [12:0]              x_mag;
  logic signed [12:0]              x_val;
  logic signed [12:0]              lo;
  logic signed [12:0]              hi;
  logic                            take;
  logic                            best_hit;
  logic signed [11:0]              best_x;
  logic [9:0]                      best_y;
  logic                            ang_busy;
  logic [6:0]                      ang;
  logic                            done_ok;
  logic                            res_load;
  logic                            out_valid;

  assign cmd.ready  = (state == S_IDLE);
  assign cmd_accept = cmd.valid && cmd.ready;
  assign ray_accept = cmd_accept && (cmd.command == rpnh_pkg::CMD_RAY);
  assign store_we   = cmd_accept && (cmd.command == rpnh_pkg::CMD_STORE)
                      && (int'(cmd.slot) < rpnh_pkg::MAX_PLATES);
  assign ray_mag    = cmd.ray_end_x[11] ? 12'(~cmd.ray_end_x + 12'sd1) : cmd.ray_end_x;

  // registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plate_count  <= rpnh_pkg::COUNT_RESET;
      plate_length <= rpnh_pkg::LENGTH_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        rpnh_pkg::REG_COUNT:  plate_count  <= cfg.data;
        rpnh_pkg::REG_LENGTH: plate_length <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    n_lim = (int'(plate_count) > rpnh_pkg::MAX_PLATES) ? rpnh_pkg::CNT_W'(rpnh_pkg::MAX_PLATES)
                                                       : rpnh_pkg::CNT_W'(plate_count);
    issue = (state == S_SCAN) && (idx < n_lim);
  end

  rpnh_ram #(
    .WIDTH ($bits(rpnh_pkg::plate_t)),
    .DEPTH (rpnh_pkg::MAX_PLATES)
  ) u_plates (
    .clk   (clk),
    .we    (store_we),
    .waddr (rpnh_pkg::PLATE_AW'(cmd.slot)),
    .wdata ({cmd.plate_x, cmd.plate_y}),
    .raddr (idx[rpnh_pkg::PLATE_AW-1:0]),
    .rdata (plate_rd)
  );

  // multiply stage: |depth * end x| split into first remainder and dividend tail
  assign prod = 22'(plate_rd.depth * ex_mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid      <= 1'b0;
      m_stage.valid <= 1'b0;
    end else begin
      rd_valid      <= issue;
      m_stage.valid <= rd_valid;
    end
    m_stage.neg   <= ex_neg;
    m_stage.left  <= plate_rd.left;
    m_stage.depth <= plate_rd.depth;
    m_stage.rem   <= {1'b0, prod[20:12]};
    m_stage.dq    <= prod[11:0];
  end

  assign chain[0] = m_stage;

  for (genvar i = 0; i < rpnh_pkg::DIV_CELLS; i++) begin : g_cell
    rpnh_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  always_comb begin
    pipe_any = rd_valid | m_stage.valid;
    for (int i = 1; i <= rpnh_pkg::DIV_CELLS; i++) begin
      pipe_any = pipe_any | chain[i].valid;
    end
  end

  // hit test on the quotient leaving the chain
  always_comb begin
    fin   = chain[rpnh_pkg::DIV_CELLS];
    x_mag = $signed({1'b0, fin.dq});
    x_val = fin.neg ? -x_mag : x_mag;
    lo    = 13'(fin.left);
    hi    = lo + $signed({5'b0, plate_length});
    take  = fin.valid && (x_val >= lo) && (x_val <= hi) && (fin.depth < best_y);
  end

  always_ff @(posedge clk) begin
    if (ray_accept) begin
      best_hit <= 1'b0;
      best_x   <= cmd.ray_end_x;
      best_y   <= 10'(rpnh_pkg::DEPTH_END);
    end else if (take) begin
      best_hit <= 1'b1;
      best_x   <= x_val[11:0];
      best_y   <= fin.depth;
    end
  end

  rpnh_angle u_angle (
    .clk   (clk),
    .rst   (rst),
    .start (ray_accept),
    .mag   (ray_mag),
    .busy  (ang_busy),
    .angle (ang)
  );

  assign done_ok  = !issue && !pipe_any && !ang_busy && (!out_valid || res.ready);
  assign res_load = (state == S_SCAN) && done_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result may replace one leaving in the same cycle
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (ray_accept) begin
            idx    <= '0;
            ex_neg <= cmd.ray_end_x[11];
            ex_mag <= ray_mag;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            idx <= idx + rpnh_pkg::CNT_W'(1);
          end else if (done_ok) begin
            res.hit       <= best_hit;
            res.end_x     <= best_x;
            res.end_y     <= best_y;
            res.angle_deg <= ang;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid = out_valid;

`include "ray_plate_nearest_hit_assert.svh"

  `RPNH_CHECK(a_accept_when_drained, cmd.valid && cmd.ready,
              !pipe_any && !ang_busy, "word accepted while a ray is in work")
  `RPNH_CHECK(a_miss_depth, res.valid,
              res.hit ? (res.end_y < 10'(rpnh_pkg::DEPTH_END))
                      : (res.end_y == 10'(rpnh_pkg::DEPTH_END)),
              "result depth disagrees with hit flag")
  `RPNH_CHECK_NEXT(a_best_monotone, state == S_SCAN && !ray_accept,
                   state != S_SCAN || best_y <= $past(best_y),
                   "nearest depth grew during a scan")

endmodule

`default_nettype wire
